// File: sv/qam_pkg.sv
// shared types, constants and helpers of the quadrotor attitude and altitude mixer
package qam_pkg;

	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_ROLL_GAIN  = 3'd0,
		REG_PITCH_GAIN = 3'd1,
		REG_ALT_GAIN   = 3'd2,
		REG_HOVER      = 3'd3,
		REG_OFFSET     = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		KEY_UP         = 3'd0,
		KEY_DOWN       = 3'd1,
		KEY_RIGHT      = 3'd2,
		KEY_LEFT       = 3'd3,
		KEY_SHIFT_RIGHT = 3'd4,
		KEY_SHIFT_LEFT = 3'd5,
		KEY_SHIFT_UP   = 3'd6,
		KEY_SHIFT_DOWN = 3'd7
	} key_code_t;

	localparam logic [14:0] RESET_ROLL_GAIN  = 15'd3200;
	localparam logic [14:0] RESET_PITCH_GAIN = 15'd1920;
	localparam logic [14:0] RESET_ALT_GAIN   = 15'd768;
	localparam logic [14:0] RESET_HOVER      = 15'd14464;
	localparam logic signed [15:0] RESET_OFFSET = 16'sd154;
	localparam logic signed [15:0] TARGET_RESET = 16'sd256;
	localparam logic signed [15:0] PITCH_PUSH   = 16'sd512;
	localparam logic signed [15:0] YAW_PUSH     = 16'sd333;
	localparam logic signed [15:0] ROLL_PUSH    = 16'sd256;
	localparam logic signed [16:0] HEIGHT_STEP  = 17'sd13;

	// microcode fields
	typedef enum logic [1:0] {A_ROLL, A_PITCH, A_ERR, A_PROD} a_sel_t;
	typedef enum logic [1:0] {B_ERR, B_RGAIN, B_PGAIN, B_AGAIN} b_sel_t;
	typedef enum logic [1:0] {WB_NONE, WB_RT, WB_PT, WB_AT} wb_t;

	typedef logic [2:0] step_t;
	localparam step_t KEY_STEP = 3'd7;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		wb_t    wb;
		logic   key_jump;
		logic   mix;
		logic   key_apply;
		logic   last;
	} uword_t;

	localparam uword_t UW_IDLE = '{a_sel: A_ROLL, b_sel: B_ERR, wb: WB_NONE,
		key_jump: 1'b0, mix: 1'b0, key_apply: 1'b0, last: 1'b0};

	// control program, one word per step
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = UW_IDLE;
		unique case (s)
			3'd0: begin
				w.key_jump = 1'b1;
				w.a_sel = A_ROLL;
				w.b_sel = B_RGAIN;
			end
			3'd1: begin
				w.wb = WB_RT;
				w.a_sel = A_PITCH;
				w.b_sel = B_PGAIN;
			end
			3'd2: begin
				w.wb = WB_PT;
				w.a_sel = A_ERR;
				w.b_sel = B_ERR;
			end
			3'd3: begin
				w.a_sel = A_PROD;
				w.b_sel = B_ERR;
			end
			3'd4: begin
				w.a_sel = A_PROD;
				w.b_sel = B_AGAIN;
			end
			3'd5: begin
				w.wb = WB_AT;
			end
			3'd6: begin
				w.mix = 1'b1;
				w.last = 1'b1;
			end
			3'd7: begin
				w.key_apply = 1'b1;
				w.last = 1'b1;
			end
			default: w = UW_IDLE;
		endcase
		return w;
	endfunction

	// clamp to one in Q8.8
	function automatic logic signed [9:0] clamp_unit(input logic signed [17:0] v);
		if (v > 18'sd256)
			return 10'sd256;
		else if (v < -18'sd256)
			return -10'sd256;
		else
			return v[9:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		if (v > 21'sd32767)
			return 16'sh7fff;
		else if (v < -21'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

// File: sv/qam_if.sv
// sensor and motor channel interfaces
interface qam_sensor_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [2:0] key_code;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] height;
	logic signed [15:0] roll_rate;
	logic signed [15:0] pitch_rate;

	modport source(output valid, cmd, key_code, roll_angle, pitch_angle, height,
		roll_rate, pitch_rate, input ready);
	modport sink(input valid, cmd, key_code, roll_angle, pitch_angle, height,
		roll_rate, pitch_rate, output ready);
endinterface

interface qam_motor_if;
	logic valid;
	logic ready;
	logic signed [15:0] front_right;
	logic signed [15:0] back_right;
	logic signed [15:0] back_left;
	logic signed [15:0] front_left;

	modport source(output valid, front_right, back_right, back_left, front_left,
		input ready);
	modport sink(input valid, front_right, back_right, back_left, front_left,
		output ready);
endinterface

// File: sv/qam_seq.sv
// microcode sequencer: step counter, control store and jump logic
module qam_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            is_key,
	input  logic            hold,
	output logic            busy,
	output qam_pkg::uword_t uw
);
	import qam_pkg::*;

	logic   busy_q;
	step_t  step_q;
	uword_t rom_w;
	logic   stall;

	always_comb begin
		rom_w = ucode(step_q);
		uw    = busy_q ? rom_w : UW_IDLE;
		stall = rom_w.mix && hold;
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else if (rom_w.key_jump && is_key) begin
			step_q <= KEY_STEP;
		end else if (rom_w.last) begin
			if (!stall)
				busy_q <= 1'b0;
		end else begin
			step_q <= step_q + 3'd1;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("item started while program running");
	a_key_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && step_q == KEY_STEP) |-> is_key)
		else $error("key step reached on a control item");
	a_mix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && rom_w.mix && hold) |=> (busy_q && step_q == $past(step_q)))
		else $error("mix step left while output stalled");

endmodule

// File: sv/quadrotor_attitude_altitude_mixer_unit.sv
// top level of the quadrotor attitude and altitude controller with motor mixer
//
//  channel  | dir | handshake     | carries
//  ---------+-----+---------------+-------------------------------------------
//  sensor   | in  | valid / ready | cmd, key_code, angles, height, rates
//  motor    | out | valid / ready | four saturated motor commands
//  wr_*     | in  | wr_en only    | register index and 16 bit data
//
// a control item runs from accept through seven program steps to the next ready,
// set by five products through one shared multiplier; a key item runs only
// steps 0 and 7 and gives no result
// reset clears the program, the output valid and the pushes, and loads the registers and target with their reset values
// an output stall holds the program at its mix step; a finished result may
// wait in the output register while the next item is accepted and worked on
module quadrotor_attitude_altitude_mixer_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	qam_sensor_if.sink                sensor,
	qam_motor_if.source               motor,
	input  logic                      wr_en,
	input  logic [qam_pkg::IDX_W-1:0] wr_index,
	input  logic [15:0]               wr_data
);
	import qam_pkg::*;

	// configuration registers
	logic [14:0] rg_q, pg_q, ag_q, hv_q;
	logic signed [15:0] off_q;

	// persistent state
	logic signed [15:0] tgt_q, roll_push_q, pitch_push_q, yaw_push_q;

	// latched item
	logic        key_q;
	logic [2:0]  code_q;
	logic signed [9:0]  roll_q, pitch_q, err_q;
	logic signed [15:0] rrate_q, prate_q;

	// datapath
	logic signed [26:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [42:0] prod, p_q;
	logic signed [42:0] r8_sum, r24_sum;
	logic signed [16:0] rnd8, rnd24;
	logic signed [18:0] rt_q, pt_q;
	logic signed [16:0] at_q;
	logic signed [17:0] err_full;
	logic signed [20:0] t_w, m_fr, m_br, m_bl, m_fl;
	logic signed [16:0] th_up, th_dn;

	// control
	logic   accept, busy, hold, mix_load;
	uword_t uw;

	assign accept       = sensor.valid && sensor.ready;
	assign sensor.ready = !busy;
	// output still full and not taken this cycle
	assign hold         = motor.valid && !motor.ready;
	assign mix_load     = uw.mix && !hold;

	qam_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.is_key (key_q),
		.hold   (hold),
		.busy   (busy),
		.uw     (uw)
	);

	// configuration writes, out of range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rg_q  <= RESET_ROLL_GAIN;
			pg_q  <= RESET_PITCH_GAIN;
			ag_q  <= RESET_ALT_GAIN;
			hv_q  <= RESET_HOVER;
			off_q <= RESET_OFFSET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROLL_GAIN:  rg_q  <= wr_data[14:0];
				REG_PITCH_GAIN: pg_q  <= wr_data[14:0];
				REG_ALT_GAIN:   ag_q  <= wr_data[14:0];
				REG_HOVER:      hv_q  <= wr_data[14:0];
				REG_OFFSET:     off_q <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	// altitude error straight off the item, clamped when latched
	assign err_full = 18'(tgt_q) - 18'(sensor.height) + 18'(off_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= 1'b0;
		end else if (accept) begin
			key_q <= sensor.cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q  <= sensor.key_code;
			roll_q  <= clamp_unit(18'(sensor.roll_angle));
			pitch_q <= clamp_unit(18'(sensor.pitch_angle));
			err_q   <= clamp_unit(err_full);
			rrate_q <= sensor.roll_rate;
			prate_q <= sensor.pitch_rate;
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (uw.a_sel)
			A_ROLL:  mul_a = 27'(roll_q);
			A_PITCH: mul_a = 27'(pitch_q);
			A_ERR:   mul_a = 27'(err_q);
			A_PROD:  mul_a = p_q[26:0];
			default: mul_a = '0;
		endcase
		case (uw.b_sel)
			B_ERR:   mul_b = 16'(err_q);
			B_RGAIN: mul_b = $signed({1'b0, rg_q});
			B_PGAIN: mul_b = $signed({1'b0, pg_q});
			B_AGAIN: mul_b = $signed({1'b0, ag_q});
			default: mul_b = '0;
		endcase
	end

	assign prod = 43'(mul_a) * 43'(mul_b);

	// round to nearest, ties upward, by taking the floor after adding half
	assign r8_sum  = p_q + 43'sd128;
	assign r24_sum = p_q + 43'sd8388608;
	assign rnd8    = r8_sum[24:8];
	assign rnd24   = r24_sum[40:24];

	always_ff @(posedge clk) begin
		p_q <= prod;
		case (uw.wb)
			WB_RT: rt_q <= 19'(rnd8) + 19'(rrate_q) + 19'(roll_push_q);
			WB_PT: pt_q <= 19'(rnd8) + 19'(prate_q) + 19'(pitch_push_q);
			WB_AT: at_q <= rnd24;
			default: ;
		endcase
	end

	// mixer
	assign t_w  = $signed(21'(hv_q)) + 21'(at_q);
	assign m_fr = t_w + 21'(rt_q) + 21'(pt_q) + 21'(yaw_push_q);
	assign m_br = t_w + 21'(rt_q) - 21'(pt_q) - 21'(yaw_push_q);
	assign m_bl = t_w - 21'(rt_q) - 21'(pt_q) + 21'(yaw_push_q);
	assign m_fl = t_w - 21'(rt_q) + 21'(pt_q) - 21'(yaw_push_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor.valid <= 1'b0;
		end else if (mix_load) begin
			motor.valid <= 1'b1;
		end else if (motor.ready) begin
			motor.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mix_load) begin
			motor.front_right <= sat16(m_fr);
			motor.back_right  <= sat16(m_br);
			motor.back_left   <= sat16(m_bl);
			motor.front_left  <= sat16(m_fl);
		end
	end

	// key events, target height saturates at the Q8.8 range
	assign th_up = 17'(tgt_q) + HEIGHT_STEP;
	assign th_dn = 17'(tgt_q) - HEIGHT_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q        <= TARGET_RESET;
			roll_push_q  <= '0;
			pitch_push_q <= '0;
			yaw_push_q   <= '0;
		end else if (uw.key_apply) begin
			case (code_q)
				KEY_UP:          pitch_push_q <= -PITCH_PUSH;
				KEY_DOWN:        pitch_push_q <= PITCH_PUSH;
				KEY_RIGHT:       yaw_push_q   <= -YAW_PUSH;
				KEY_LEFT:        yaw_push_q   <= YAW_PUSH;
				KEY_SHIFT_RIGHT: roll_push_q  <= -ROLL_PUSH;
				KEY_SHIFT_LEFT:  roll_push_q  <= ROLL_PUSH;
				KEY_SHIFT_UP:    tgt_q <= (th_up > 17'sd32767) ? 16'sh7fff : th_up[15:0];
				default:         tgt_q <= (th_dn < -17'sd32768) ? 16'sh8000 : th_dn[15:0];
			endcase
		end
	end

	a_out_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(motor.valid) |-> $past(mix_load))
		else $error("result appeared without a mix step");
	a_key_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		uw.mix |-> !key_q) else $error("mix step run for a key item");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(motor.valid && !motor.ready) |=> (motor.valid
		&& $stable(motor.front_right) && $stable(motor.back_right)
		&& $stable(motor.back_left) && $stable(motor.front_left)))
		else $error("waiting motor item changed");

endmodule

// File: bench/quadrotor_attitude_altitude_mixer_unit_tb.sv
// self-checking bench for the quadrotor attitude and altitude mixer: directed rows, key runs, random
module quadrotor_attitude_altitude_mixer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qam_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 7;
	// a key item may still be in flight when the last motor item shows up
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int MAX_REPORTS   = 10;
	localparam longint RUN_LIMIT_NS = 64'd10_000_000;

	localparam logic CMD_CONTROL = 1'b0;
	localparam logic CMD_KEY     = 1'b1;

	// disturbance and target steps that the keys apply
	localparam longint PITCH_KEY_STEP = 512;
	localparam longint YAW_KEY_STEP   = 333;
	localparam longint ROLL_KEY_STEP  = 256;
	localparam longint TARGET_STEP    = 13;
	localparam longint UNIT_Q8        = 256;

	typedef struct packed {
		logic               cmd;
		key_code_t          key_code;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] height;
		logic signed [15:0] roll_rate;
		logic signed [15:0] pitch_rate;
	} sensor_item_t;

	typedef struct packed {
		logic signed [15:0] front_right;
		logic signed [15:0] back_right;
		logic signed [15:0] back_left;
		logic signed [15:0] front_left;
	} motor_item_t;

	// one directed row: the sensor item and, where obvious, its motor item
	typedef struct packed {
		sensor_item_t item;
		logic         typed;
		motor_item_t  motors;
	} stim_row_t;

	localparam motor_item_t NO_MOTORS = '0;
	localparam int N_DIRECTED = 21;

	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// straight after reset, level and on the ground: hover plus full climb term
		'{'{CMD_CONTROL, KEY_UP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
			1'b1, '{16'sd15232, 16'sd15232, 16'sd15232, 16'sd15232}},
		// both rates at full scale: one motor saturates high, one low
		'{'{CMD_CONTROL, KEY_UP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff},
			1'b1, '{16'sh7fff, 16'sd15232, 16'sh8000, 16'sd15232}},
		// field extremes
		'{'{CMD_CONTROL, KEY_SHIFT_DOWN, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000},
			1'b0, NO_MOTORS},
		'{'{CMD_CONTROL, KEY_UP, 16'sd256, -16'sd256, 16'sh7fff, 16'sh0000, 16'sh0000},
			1'b0, NO_MOTORS},
		// just past the angle clamp, zero altitude error
		'{'{CMD_CONTROL, KEY_UP, 16'sd257, -16'sd257, 16'sd410, 16'sh0001, 16'shffff},
			1'b0, NO_MOTORS},
		// just inside the clamp, error of minus one lsb
		'{'{CMD_CONTROL, KEY_UP, -16'sd255, 16'sd255, 16'sd411, 16'sh5555, 16'shaaaa},
			1'b0, NO_MOTORS},
		// every key once, with junk in the unused fields
		'{'{CMD_KEY, KEY_UP, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff},
			1'b0, NO_MOTORS},
		'{'{CMD_KEY, KEY_DOWN, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555},
			1'b0, NO_MOTORS},
		'{'{CMD_KEY, KEY_RIGHT, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa},
			1'b0, NO_MOTORS},
		'{'{CMD_KEY, KEY_LEFT, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
			1'b0, NO_MOTORS},
		'{'{CMD_KEY, KEY_SHIFT_RIGHT, 16'sh0000, 16'shffff, 16'sh0000, 16'shffff, 16'sh0000},
			1'b0, NO_MOTORS},
		'{'{CMD_KEY, KEY_SHIFT_LEFT, 16'shffff, 16'sh0000, 16'shffff, 16'sh0000, 16'shffff},
			1'b0, NO_MOTORS},
		'{'{CMD_KEY, KEY_SHIFT_UP, 16'sh1234, 16'sh4321, 16'shf00f, 16'sh0ff0, 16'sh3c3c},
			1'b0, NO_MOTORS},
		'{'{CMD_KEY, KEY_SHIFT_DOWN, 16'shc3c3, 16'sh0ff0, 16'sh0ff0, 16'shf00f, 16'sh1234},
			1'b0, NO_MOTORS},
		// disturbances held from the keys above, key field ignored
		'{'{CMD_CONTROL, KEY_SHIFT_DOWN, 16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd0},
			1'b0, NO_MOTORS},
		// flip every disturbance the other way
		'{'{CMD_KEY, KEY_UP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
			1'b0, NO_MOTORS},
		'{'{CMD_KEY, KEY_RIGHT, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
			1'b0, NO_MOTORS},
		'{'{CMD_KEY, KEY_SHIFT_RIGHT, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
			1'b0, NO_MOTORS},
		'{'{CMD_CONTROL, KEY_SHIFT_UP, 16'sd0, 16'sd0, 16'sd410, 16'sh8000, 16'sh7fff},
			1'b0, NO_MOTORS},
		// one step up in target, then sit right on it
		'{'{CMD_KEY, KEY_SHIFT_UP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
			1'b0, NO_MOTORS},
		'{'{CMD_CONTROL, KEY_LEFT, 16'sd1, -16'sd1, 16'sd423, 16'sd0, 16'sd0},
			1'b0, NO_MOTORS}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [15:0] wr_data;

	qam_sensor_if sensor_ch();
	qam_motor_if  motor_ch();

	quadrotor_attitude_altitude_mixer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sensor   (sensor_ch),
		.motor    (motor_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// shadow of the controller: gains, thrust, offset, target and disturbances
	logic [14:0]        k_roll      = 15'd3200;
	logic [14:0]        k_pitch     = 15'd1920;
	logic [14:0]        k_alt       = 15'd768;
	logic [14:0]        base_thrust = 15'd14464;
	logic signed [15:0] cg_height   = 16'sd154;
	logic signed [15:0] alt_target  = 16'sd256;
	logic signed [15:0] roll_bias   = 16'sd0;
	logic signed [15:0] pitch_bias  = 16'sd0;
	logic signed [15:0] yaw_bias    = 16'sd0;

	motor_item_t pending_motors [$];

	int  failures = 0;
	int  reports  = 0;
	bit  gaps_on  = 1'b1;
	bit  stall_on = 1'b1;
	bit  hold_req = 1'b0;

	function automatic longint bound(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic signed [15:0] saturate(input longint v);
		return 16'(bound(v, -32768, 32767));
	endfunction

	// round to nearest, ties up, after dropping s fraction bits
	function automatic longint round_drop(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// expected motor commands of one control item under the current shadow state
	function automatic motor_item_t mix_motors(input sensor_item_t it);
		longint roll, pitch, err, rt, pt, yt, at, base;
		motor_item_t m;
		roll  = bound(longint'(it.roll_angle), -UNIT_Q8, UNIT_Q8);
		pitch = bound(longint'(it.pitch_angle), -UNIT_Q8, UNIT_Q8);
		rt = round_drop(longint'(k_roll) * roll, 8) + longint'(it.roll_rate)
			+ longint'(roll_bias);
		pt = round_drop(longint'(k_pitch) * pitch, 8) + longint'(it.pitch_rate)
			+ longint'(pitch_bias);
		yt = longint'(yaw_bias);
		err = bound(longint'(alt_target) - longint'(it.height) + longint'(cg_height),
			-UNIT_Q8, UNIT_Q8);
		// cubic term stays within 2^24 before the gain
		at = round_drop(longint'(k_alt) * (err * err * err), 24);
		base = longint'(base_thrust) + at;
		m.front_right = saturate(base + rt + pt + yt);
		m.back_right  = saturate(base + rt - pt - yt);
		m.back_left   = saturate(base - rt - pt + yt);
		m.front_left  = saturate(base - rt + pt - yt);
		return m;
	endfunction

	task automatic apply_key(input key_code_t k);
		case (k)
			KEY_UP:          pitch_bias = 16'(-PITCH_KEY_STEP);
			KEY_DOWN:        pitch_bias = 16'(PITCH_KEY_STEP);
			KEY_RIGHT:       yaw_bias = 16'(-YAW_KEY_STEP);
			KEY_LEFT:        yaw_bias = 16'(YAW_KEY_STEP);
			KEY_SHIFT_RIGHT: roll_bias = 16'(-ROLL_KEY_STEP);
			KEY_SHIFT_LEFT:  roll_bias = 16'(ROLL_KEY_STEP);
			KEY_SHIFT_UP:    alt_target = saturate(longint'(alt_target) + TARGET_STEP);
			default:         alt_target = saturate(longint'(alt_target) - TARGET_STEP);
		endcase
	endtask

	task automatic apply_register_write(input logic [IDX_W-1:0] idx, input logic [15:0] data);
		case (idx)
			REG_ROLL_GAIN:  k_roll = data[14:0];
			REG_PITCH_GAIN: k_pitch = data[14:0];
			REG_ALT_GAIN:   k_alt = data[14:0];
			REG_HOVER:      base_thrust = data[14:0];
			REG_OFFSET:     cg_height = data;
			default: ;
		endcase
	endtask

	// angles: full range, around the clamp, or inside it
	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(2))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(600)) - 300);
			default: return 16'(int'($urandom_range(512)) - 256);
		endcase
	endfunction

	// height mostly near the target so the altitude error mostly stays inside its clamp
	function automatic logic signed [15:0] pick_height();
		if ($urandom_range(3) == 0)
			return 16'($urandom);
		return 16'(int'(alt_target) + int'(cg_height) + int'($urandom_range(600)) - 300);
	endfunction

	function automatic logic signed [15:0] pick_rate();
		if ($urandom_range(2) == 0)
			return 16'($urandom);
		return 16'(int'($urandom_range(4000)) - 2000);
	endfunction

	function automatic sensor_item_t make_random_item(input bit control_only);
		sensor_item_t it;
		it.cmd = (!control_only && $urandom_range(99) < 25) ? CMD_KEY : CMD_CONTROL;
		it.key_code    = key_code_t'($urandom_range(7));
		it.roll_angle  = pick_angle();
		it.pitch_angle = pick_angle();
		it.height      = pick_height();
		it.roll_rate   = pick_rate();
		it.pitch_rate  = pick_rate();
		return it;
	endfunction

	// entered and left at a falling edge; valid stays up for a back-to-back item
	task automatic offer_sensor_item(input sensor_item_t it, input logic typed,
			input motor_item_t typed_motors);
		while (gaps_on && $urandom_range(99) < 20) begin
			sensor_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sensor_ch.valid       <= 1'b1;
		sensor_ch.cmd         <= it.cmd;
		sensor_ch.key_code    <= it.key_code;
		sensor_ch.roll_angle  <= it.roll_angle;
		sensor_ch.pitch_angle <= it.pitch_angle;
		sensor_ch.height      <= it.height;
		sensor_ch.roll_rate   <= it.roll_rate;
		sensor_ch.pitch_rate  <= it.pitch_rate;
		do
			@(posedge clk);
		while (!sensor_ch.ready);
		// item taken: update the shadow state or queue the motor item it will give
		if (it.cmd == CMD_KEY)
			apply_key(it.key_code);
		else
			pending_motors.push_back(typed ? typed_motors : mix_motors(it));
		@(negedge clk);
	endtask

	task automatic run_random(input int n, input bit control_only);
		repeat (n)
			offer_sensor_item(make_random_item(control_only), 1'b0, NO_MOTORS);
	endtask

	task automatic run_key(input key_code_t k, input int n);
		sensor_item_t it;
		repeat (n) begin
			it = make_random_item(1'b1);
			it.cmd = CMD_KEY;
			it.key_code = k;
			offer_sensor_item(it, 1'b0, NO_MOTORS);
		end
	endtask

	// sender quiet until every motor item is in, then let a key item finish
	task automatic settle_idle();
		sensor_ch.valid <= 1'b0;
		while (pending_motors.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// all five registers, then junk into the unused indexes
	task automatic program_registers(input logic [15:0] rg, input logic [15:0] pg,
			input logic [15:0] ag, input logic [15:0] hv, input logic [15:0] off);
		logic [15:0] vals [5];
		logic [15:0] data;
		vals = '{rg, pg, ag, hv, off};
		settle_idle();
		for (int i = 0; i < 2 ** IDX_W; i++) begin
			data = (i <= int'(REG_OFFSET)) ? vals[i] : 16'($urandom);
			wr_en    <= 1'b1;
			wr_index <= IDX_W'(i);
			wr_data  <= data;
			apply_register_write(IDX_W'(i), data);
			@(negedge clk);
		end
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		motor_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				motor_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			motor_ch.ready <= (!stall_on || $urandom_range(99) >= 20);
		end
	end

	// compare each motor item with the oldest one waiting
	always @(posedge clk) begin
		motor_item_t got, want;
		if (arst_n && motor_ch.valid && motor_ch.ready) begin
			got = '{motor_ch.front_right, motor_ch.back_right,
				motor_ch.back_left, motor_ch.front_left};
			if (pending_motors.size() == 0) begin
				failures++;
				if (reports++ < MAX_REPORTS)
					$display("unexpected motor item fr=%0d br=%0d bl=%0d fl=%0d",
						got.front_right, got.back_right, got.back_left, got.front_left);
			end else begin
				want = pending_motors.pop_front();
				if (got !== want) begin
					failures++;
					if (reports++ < MAX_REPORTS)
						$display("motor mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
							want.front_right, want.back_right, want.back_left,
							want.front_left, got.front_right, got.back_right,
							got.back_left, got.front_left);
				end
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n                = 1'b0;
		wr_en                 = 1'b0;
		wr_index              = '0;
		wr_data               = '0;
		sensor_ch.valid       = 1'b0;
		sensor_ch.cmd         = CMD_CONTROL;
		sensor_ch.key_code    = KEY_UP;
		sensor_ch.roll_angle  = '0;
		sensor_ch.pitch_angle = '0;
		sensor_ch.height      = '0;
		sensor_ch.roll_rate   = '0;
		sensor_ch.pitch_rate  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: directed rows, then random items
		for (int r = 0; r < N_DIRECTED; r++)
			offer_sensor_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed,
				DIRECTED_ROWS[r].motors);
		run_random(100, 1'b0);

		// every register at its top, bit 15 set on the narrow ones; no idling at all
		program_registers(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h7fff);
		gaps_on  = 1'b0;
		stall_on = 1'b0;
		run_random(80, 1'b0);
		gaps_on  = 1'b1;
		stall_on = 1'b1;

		// everything at the bottom; the receiver holds off while items pile up
		program_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
		hold_req = 1'b1;
		run_random(80, 1'b0);

		// random settings
		repeat (3) begin
			program_registers(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom));
			run_random(80, 1'b0);
		end

		// short runs of height keys with control items in between
		program_registers(16'd3200, 16'd1920, 16'd768, 16'd14464, 16'd154);
		run_key(KEY_SHIFT_UP, 12);
		run_random(6, 1'b1);
		run_key(KEY_SHIFT_DOWN, 24);
		run_random(6, 1'b1);
		run_key(KEY_SHIFT_UP, 12);

		// sender pauses mid-stream until every motor item is in
		run_random(50, 1'b0);
		settle_idle();
		run_random(50, 1'b0);

		// end of stimulus: let the last items out, bounded
		sensor_ch.valid <= 1'b0;
		for (int c = 0; c < DRAIN_LIMIT && pending_motors.size() != 0; c++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_motors.size() != 0) begin
			failures++;
			$display("%0d motor items never arrived", pending_motors.size());
		end

		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
